@@ design/bcfp_pkg.sv @@
// Shared types and constants for the BiSS-C frame parser.
// No dependencies; bcfp_ctrl, bcfp_datapath and the top level import this package.
`default_nettype none

package bcfp_pkg;

  localparam int unsigned MaxFrameBytes = 16;
  localparam int unsigned PosMaxWidth   = 24;
  localparam int unsigned CrcBits       = 6;
  localparam int unsigned CrcWordBits   = PosMaxWidth + 2;

  localparam logic [CrcBits-1:0] CrcPoly   = 6'h03;
  localparam logic [CrcBits-1:0] CrcXorOut = 6'h3F;

  localparam logic [4:0] FrameLenReset = 5'd8;
  localparam logic [5:0] DataBitsReset = 6'd32;
  localparam logic [4:0] PosWidthReset = 5'd24;
  localparam logic [4:0] ResReset      = 5'd24;

  typedef enum logic [2:0] {
    CFG_FRAME_LEN  = 3'd0,
    CFG_DATA_BITS  = 3'd1,
    CFG_POS_WIDTH  = 3'd2,
    CFG_RESOLUTION = 3'd3,
    CFG_ERR_LOW    = 3'd4,
    CFG_WARN_LOW   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_ONES    = 3'd0,
    PH_ZEROS   = 3'd1,
    PH_SKIP    = 3'd2,
    PH_CAPTURE = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NORESP = 3'd1,
    ST_CRC    = 3'd2,
    ST_SENSOR = 3'd3,
    ST_WARN   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BITS,
    S_CHECK,
    S_CRC,
    S_EMIT
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       bit_step;
    logic       byte_done;
    logic       crc_clr;
    logic       crc_step;
    logic [4:0] crc_idx;
    logic       emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       skip_item;
    logic       frame_end;
    logic       resp_ok;
    logic [4:0] crc_len;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ design/bcfp_intf.sv @@
// Handshake channel interfaces for the BiSS-C frame parser.
// Depends on bcfp_pkg for nothing but shares its field widths.
`default_nettype none

interface bcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface bcfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] abs_position;
  logic [23:0] scaled_position;
  logic        error_flag;
  logic        warning_flag;

  modport source (output valid, output status, output abs_position,
                  output scaled_position, output error_flag, output warning_flag,
                  input ready);
  modport sink   (input valid, input status, input abs_position,
                  input scaled_position, input error_flag, input warning_flag,
                  output ready);
endinterface

interface bcfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [5:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/bcfp_ctrl.sv @@
// Sequencer for the frame parser: walks bits of a word, runs the CRC loop, emits.
// Depends on bcfp_pkg.
`default_nettype none

module bcfp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bcfp_pkg::stat_t stat_i,
  output bcfp_pkg::cmd_t      cmd_o
);
  import bcfp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !stat_i.skip_item) state_d = S_BITS;
      end
      S_BITS: begin
        if (cnt_q == 5'd7) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!stat_i.frame_end) state_d = S_IDLE;
        else if (stat_i.resp_ok) state_d = S_CRC;
        else state_d = S_EMIT;
      end
      S_CRC: begin
        if (cnt_q == 5'd1) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and counter
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = accept;
        cnt_d      = '0;
      end
      S_BITS: begin
        cmd_o.bit_step  = 1'b1;
        cmd_o.byte_done = (cnt_q == 5'd7);
        cnt_d           = cnt_q + 5'd1;
      end
      S_CHECK: begin
        cmd_o.crc_clr = 1'b1;
        cnt_d         = stat_i.crc_len;
      end
      S_CRC: begin
        cmd_o.crc_step = 1'b1;
        cmd_o.crc_idx  = cnt_q - 5'd1;
        cnt_d          = cnt_q - 5'd1;
      end
      S_EMIT: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/bcfp_datapath.sv @@
// Datapath of the frame parser: config registers, bit parser, CRC-6, result register.
// Depends on bcfp_pkg; driven by commands from bcfp_ctrl.
`default_nettype none

module bcfp_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [5:0]      cfg_data_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            frame_start_i,
  input  wire bcfp_pkg::cmd_t  cmd_i,
  output bcfp_pkg::stat_t      stat_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic [2:0]           status_o,
  output logic [23:0]          abs_position_o,
  output logic [23:0]          scaled_position_o,
  output logic                 error_flag_o,
  output logic                 warning_flag_o
);
  import bcfp_pkg::*;

  // configuration
  logic [4:0] flen_q, pw_q, res_q;
  logic [5:0] dwb_q;
  logic       eal_q, wal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q <= FrameLenReset;
      dwb_q  <= DataBitsReset;
      pw_q   <= PosWidthReset;
      res_q  <= ResReset;
      eal_q  <= 1'b0;
      wal_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_LEN:  flen_q <= cfg_data_i[4:0];
        CFG_DATA_BITS:  dwb_q  <= cfg_data_i;
        CFG_POS_WIDTH:  pw_q   <= cfg_data_i[4:0];
        CFG_RESOLUTION: res_q  <= cfg_data_i[4:0];
        CFG_ERR_LOW:    eal_q  <= cfg_data_i[0];
        CFG_WARN_LOW:   wal_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [4:0] len_sat, pw_sat, res_sat, scale_amt;

  always_comb begin
    len_sat = flen_q;
    if (flen_q == 5'd0) len_sat = 5'd1;
    else if (flen_q > 5'(MaxFrameBytes)) len_sat = 5'(MaxFrameBytes);
    pw_sat = pw_q;
    if (pw_q == 5'd0) pw_sat = 5'd1;
    else if (pw_q > 5'(PosMaxWidth)) pw_sat = 5'(PosMaxWidth);
    res_sat = res_q;
    if (res_q == 5'd0) res_sat = 5'd1;
    else if (res_q > pw_sat) res_sat = pw_sat;
    scale_amt = pw_sat - res_sat;
  end

  // parser state
  phase_e      phase_q, phase_d;
  logic [4:0]  byte_cnt_q, byte_cnt_d;
  logic [1:0]  skip_q, skip_d;
  logic [31:0] shift_q, shift_d;
  logic [5:0]  dbits_q, dbits_d;
  logic [7:0]  byte_q, byte_d;
  logic [5:0]  crc_q, crc_d;
  logic        bit_in, crc_fb, skip_item;

  assign skip_item = !frame_start_i && (phase_q == PH_DONE);
  assign bit_in    = byte_q[7];
  assign crc_fb    = crc_q[5] ^ shift_q[6 + {27'd0, cmd_i.crc_idx}];

  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    skip_d     = skip_q;
    shift_d    = shift_q;
    dbits_d    = dbits_q;
    byte_d     = byte_q;
    crc_d      = crc_q;

    if (cmd_i.load) begin
      byte_d = rx_byte_i;
      // new frame: clear the parser
      if (frame_start_i) begin
        phase_d    = PH_ONES;
        byte_cnt_d = '0;
        skip_d     = '0;
        shift_d    = '0;
        dbits_d    = '0;
      end
    end

    if (cmd_i.bit_step) begin
      byte_d = {byte_q[6:0], 1'b0};
      unique case (phase_q)
        PH_ONES: begin
          if (!bit_in) phase_d = PH_ZEROS;
        end
        PH_ZEROS: begin
          if (bit_in) begin
            phase_d = PH_SKIP;
            skip_d  = 2'd1;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q + 2'd1;
          if (skip_d >= 2'd2) phase_d = PH_CAPTURE;
        end
        PH_CAPTURE: begin
          if (dbits_q < dwb_q) begin
            shift_d = {shift_q[30:0], bit_in};
            dbits_d = dbits_q + 6'd1;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.byte_done) byte_cnt_d = byte_cnt_q + 5'd1;

    if (cmd_i.crc_clr) crc_d = '0;
    if (cmd_i.crc_step) crc_d = {crc_q[4:0], 1'b0} ^ (crc_fb ? CrcPoly : 6'd0);

    if (cmd_i.emit) phase_d = PH_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ONES;
      byte_cnt_q <= '0;
      skip_q     <= '0;
      shift_q    <= '0;
      dbits_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      skip_q     <= skip_d;
      shift_q    <= shift_d;
      dbits_q    <= dbits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    crc_q  <= crc_d;
  end

  logic resp_ok;
  assign resp_ok = (phase_q == PH_CAPTURE) && (dbits_q >= dwb_q);

  // result assembly
  logic [23:0] raw;
  logic        eb, wb;
  status_e     status_n;

  assign raw = shift_q[31:8];
  assign eb  = shift_q[7];
  assign wb  = shift_q[6];

  always_comb begin
    if (!resp_ok) status_n = ST_NORESP;
    else if (shift_q[5:0] != (crc_q ^ CrcXorOut)) status_n = ST_CRC;
    else if (eb != eal_q) status_n = ST_SENSOR;
    else if (wb != wal_q) status_n = ST_WARN;
    else status_n = ST_OK;
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o          <= status_n;
      abs_position_o    <= resp_ok ? raw : '0;
      scaled_position_o <= resp_ok ? (raw >> scale_amt) : '0;
      error_flag_o      <= resp_ok && eb;
      warning_flag_o    <= resp_ok && wb;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.skip_item = skip_item;
  assign stat_o.frame_end = (byte_cnt_q >= len_sat);
  assign stat_o.resp_ok   = resp_ok;
  assign stat_o.crc_len   = pw_sat + 5'd2;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

@@ design/biss_c_frame_parser.sv @@
// Top level of the BiSS-C frame parser with CRC-6 check.
// Depends on bcfp_pkg, bcfp_intf, bcfp_ctrl and bcfp_datapath.
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+----------
//  in_ch    | in  | rx_byte[7:0], frame_start                      | valid/ready
//  out_ch   | out | status, abs_position, scaled_position, flags   | valid/ready
//  cfg_ch   | in  | index[2:0], data[5:0]                          | valid/ready
//
// Each word passes through accept, eight bit steps through the shared parser and one
// frame-end check. The last word of a frame also loads the result register, preceded
// by the serial CRC-6 loop over position_width+2 bits when a data word was captured.
// Words after a finished frame without frame_start are accepted and dropped.
// A held result stalls the parser only at the load step; input is taken until then.
// Reset is asynchronous; the parser comes up in the idle-ones phase.
`default_nettype none

module biss_c_frame_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bcfp_in_if.sink   in_ch,
  bcfp_out_if.source out_ch,
  bcfp_cfg_if.sink  cfg_ch
);
  import bcfp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  bcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bcfp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_ch.valid),
    .cfg_index_i       (cfg_ch.index),
    .cfg_data_i        (cfg_ch.data),
    .rx_byte_i         (in_ch.rx_byte),
    .frame_start_i     (in_ch.frame_start),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .status_o          (out_ch.status),
    .abs_position_o    (out_ch.abs_position),
    .scaled_position_o (out_ch.scaled_position),
    .error_flag_o      (out_ch.error_flag),
    .warning_flag_o    (out_ch.warning_flag)
  );

endmodule

`default_nettype wire

@@ tb/sv/biss_c_frame_parser_tb.sv @@
// Self-checking testbench for biss_c_frame_parser: drives frame bytes, tracks the parser
// in a behavioral model and checks every frame result field by field.
// Depends on bcfp_pkg and the channel interfaces in bcfp_intf.
`timescale 1ns / 100ps

module biss_c_frame_parser_tb;
  import bcfp_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 48;
  localparam int LogLimit     = 100;

  // indexes past the last register; writes to them must be dropped
  localparam logic [2:0] CfgSpareLo = 3'd6;
  localparam logic [2:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_word_t;

  typedef struct packed {
    status_e     status;
    logic [23:0] raw;
    logic [23:0] scaled;
    logic        err;
    logic        warn;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bcfp_in_if  in_ch ();
  bcfp_out_if out_ch ();
  bcfp_cfg_if cfg_ch ();

  biss_c_frame_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rx_word_t rx_pending[$];
  reading_t readings_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  // register copies
  logic [4:0] cfg_frame_len;
  logic [5:0] cfg_data_bits;
  logic [4:0] cfg_pos_width;
  logic [4:0] cfg_resolution;
  logic       cfg_err_low;
  logic       cfg_warn_low;

  // parser copy
  phase_e      ph;
  logic [4:0]  byte_cnt;
  logic [1:0]  skip_cnt;
  logic [31:0] shift_reg;
  logic [5:0]  bit_cnt;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what);
    // hold the log to the first hundred
    if (mismatches < LogLimit) begin
      $display("%0t mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic int eff_frame_len();
    if (cfg_frame_len < 1) return 1;
    if (cfg_frame_len > MaxFrameBytes) return MaxFrameBytes;
    return cfg_frame_len;
  endfunction

  function automatic int eff_pos_width();
    if (cfg_pos_width < 1) return 1;
    if (cfg_pos_width > PosMaxWidth) return PosMaxWidth;
    return cfg_pos_width;
  endfunction

  function automatic int eff_resolution(int pw);
    if (cfg_resolution < 1) return 1;
    if (cfg_resolution > pw) return pw;
    return cfg_resolution;
  endfunction

  // serial CRC-6 over the low nbits of word, top bit first
  function automatic logic [5:0] crc6_of(logic [25:0] word, int nbits);
    logic [5:0] crc;
    logic       fb;
    crc = '0;
    for (int i = nbits; i > 0; i--) begin
      fb  = crc[5] ^ word[i-1];
      crc = {crc[4:0], 1'b0};
      if (fb) crc ^= CrcPoly;
    end
    return crc ^ CrcXorOut;
  endfunction

  task automatic restart_tracker();
    ph        = PH_ONES;
    byte_cnt  = '0;
    skip_cnt  = '0;
    shift_reg = '0;
    bit_cnt   = '0;
  endtask

  function automatic reading_t frame_reading();
    reading_t    r;
    int          pw;
    int          rs;
    logic [23:0] raw;
    logic        eb;
    logic        wb;
    pw = eff_pos_width();
    rs = eff_resolution(pw);
    r = '0;
    r.status = ST_NORESP;
    if (ph != PH_CAPTURE || bit_cnt < cfg_data_bits) return r;
    raw = shift_reg[31:8];
    eb  = shift_reg[7];
    wb  = shift_reg[6];
    if (shift_reg[5:0] != crc6_of({raw, eb, wb}, pw + 2)) r.status = ST_CRC;
    else if (eb != cfg_err_low) r.status = ST_SENSOR;
    else if (wb != cfg_warn_low) r.status = ST_WARN;
    else r.status = ST_OK;
    r.raw    = raw;
    r.scaled = raw >> (pw - rs);
    r.err    = eb;
    r.warn   = wb;
    return r;
  endfunction

  // advance the parser copy by one accepted word
  task automatic track_word(rx_word_t w);
    logic b;
    if (w.frame_start) restart_tracker();
    if (ph == PH_DONE) return;
    for (int i = 7; i >= 0; i--) begin
      b = w.rx_byte[i];
      case (ph)
        PH_ONES: if (!b) ph = PH_ZEROS;
        PH_ZEROS: if (b) begin
          ph       = PH_SKIP;
          skip_cnt = 2'd1;
        end
        PH_SKIP: begin
          skip_cnt = skip_cnt + 2'd1;
          if (skip_cnt >= 2'd2) ph = PH_CAPTURE;
        end
        PH_CAPTURE: if (bit_cnt < cfg_data_bits) begin
          shift_reg = {shift_reg[30:0], b};
          bit_cnt   = bit_cnt + 6'd1;
        end
        default: ;
      endcase
    end
    byte_cnt = byte_cnt + 5'd1;
    if (byte_cnt >= eff_frame_len()) begin
      readings_due.push_back(frame_reading());
      ph = PH_DONE;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [5:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_FRAME_LEN:  cfg_frame_len  = val[4:0];
      CFG_DATA_BITS:  cfg_data_bits  = val;
      CFG_POS_WIDTH:  cfg_pos_width  = val[4:0];
      CFG_RESOLUTION: cfg_resolution = val[4:0];
      CFG_ERR_LOW:    cfg_err_low    = val[0];
      CFG_WARN_LOW:   cfg_warn_low   = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [5:0] flen, logic [5:0] dbits, logic [5:0] pw,
                               logic [5:0] res, logic [5:0] el, logic [5:0] wl);
    write_reg(CFG_FRAME_LEN, flen);
    write_reg(CFG_DATA_BITS, dbits);
    write_reg(CFG_POS_WIDTH, pw);
    write_reg(CFG_RESOLUTION, res);
    write_reg(CFG_ERR_LOW, el);
    write_reg(CFG_WARN_LOW, wl);
  endtask

  // wait until every word is in and every result out, then let the parser go quiet
  task automatic settle();
    while (rx_pending.size() != 0 || in_ch.valid || readings_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // pad bits with random ones and zeros to nbytes and queue them MSB first
  task automatic pack_frame(bit bits[$], int nbytes, bit fs);
    rx_word_t w;
    while (bits.size() < nbytes * 8) bits.push_back(1'($urandom_range(1)));
    for (int k = 0; k < nbytes; k++) begin
      for (int j = 0; j < 8; j++) w.rx_byte[7-j] = bits[k*8+j];
      w.frame_start = fs && (k == 0);
      rx_pending.push_back(w);
    end
  endtask

  task automatic queue_frame(logic [23:0] pos, logic eb, logic wb, bit crc_ok, bit fs,
                             int ones, int zeros);
    bit          bits[$];
    logic [31:0] word;
    word = {pos, eb, wb, crc6_of({pos, eb, wb}, eff_pos_width() + 2)};
    if (!crc_ok) word[5:0] ^= 6'($urandom_range(63, 1));
    repeat (ones) bits.push_back(1'b1);
    repeat (zeros) bits.push_back(1'b0);
    bits.push_back(1'b1);
    bits.push_back(1'($urandom_range(1)));
    // a long data word keeps only its last 32 bits
    for (int i = cfg_data_bits; i > 0; i--)
      bits.push_back(i > 32 ? 1'($urandom_range(1)) : word[i-1]);
    pack_frame(bits, eff_frame_len(), fs);
  endtask

  task automatic random_frame();
    bit          no_bits[$];
    int          room;
    int          ones;
    int          zeros;
    logic [23:0] pos;
    logic        eb;
    logic        wb;
    room = eff_frame_len() * 8 - 2 - int'(cfg_data_bits);
    if (room < 1) begin
      pack_frame(no_bits, eff_frame_len(), 1'b1);
      return;
    end
    ones  = $urandom_range(room - 1 < 12 ? room - 1 : 12, 0);
    zeros = $urandom_range(room - ones < 6 ? room - ones : 6, 1);
    case ($urandom_range(3))
      0: pos = '0;
      1: pos = '1;
      default: pos = 24'($urandom);
    endcase
    eb = ($urandom_range(99) < 25) ? ~cfg_err_low : cfg_err_low;
    wb = ($urandom_range(99) < 25) ? ~cfg_warn_low : cfg_warn_low;
    queue_frame(pos, eb, wb, $urandom_range(99) < 85, 1'b1, ones, zeros);
  endtask

  task automatic run_setting(int n_words);
    bit no_bits[$];
    bit all_ones[$];
    int queued;
    int pick;
    int was;
    queued = 0;
    while (queued < n_words) begin
      pick = $urandom_range(99);
      was  = rx_pending.size();
      if (pick < 72) begin
        random_frame();
      end else if (pick < 82) begin
        // cut-off frame of noise
        pack_frame(no_bits, $urandom_range(eff_frame_len(), 1), 1'b1);
      end else if (pick < 92) begin
        // stray words without frame_start, mostly dropped
        pack_frame(no_bits, $urandom_range(3, 1), 1'b0);
        continue;
      end else begin
        all_ones.delete();
        repeat (eff_frame_len() * 8) all_ones.push_back(1'b1);
        pack_frame(all_ones, eff_frame_len(), 1'b1);
      end
      queued += rx_pending.size() - was;
    end
    settle();
  endtask

  always @(posedge clk_i) begin : byte_driver
    rx_word_t took;
    rx_word_t nxt;
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.rx_byte     <= '0;
      in_ch.frame_start <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        took.rx_byte     = in_ch.rx_byte;
        took.frame_start = in_ch.frame_start;
        track_word(took);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = rx_pending.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.rx_byte     <= nxt.rx_byte;
          in_ch.frame_start <= nxt.frame_start;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    reading_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result with no frame pending");
        end else begin
          want = readings_due.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, want %s", out_ch.status,
                                      want.status.name()));
          if (out_ch.abs_position !== want.raw)
            report_mismatch($sformatf("abs_position %h, want %h", out_ch.abs_position,
                                      want.raw));
          if (out_ch.scaled_position !== want.scaled)
            report_mismatch($sformatf("scaled_position %h, want %h",
                                      out_ch.scaled_position, want.scaled));
          if (out_ch.error_flag !== want.err)
            report_mismatch($sformatf("error_flag %b, want %b", out_ch.error_flag,
                                      want.err));
          if (out_ch.warning_flag !== want.warn)
            report_mismatch($sformatf("warning_flag %b, want %b", out_ch.warning_flag,
                                      want.warn));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // count cycles with no word moving on any channel
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    bit no_bits[$];
    bit all_ones[$];
    rst_ni            = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_FRAME_LEN;
    cfg_ch.data       = '0;
    cfg_frame_len     = FrameLenReset;
    cfg_data_bits     = DataBitsReset;
    cfg_pos_width     = PosWidthReset;
    cfg_resolution    = ResReset;
    cfg_err_low       = 1'b0;
    cfg_warn_low      = 1'b0;
    restart_tracker();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 57;

    // first frame right after reset, no frame_start needed
    queue_frame(24'hFFFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 3, 2);
    // stray word after the frame, dropped
    rx_pending.push_back('{8'h00, 1'b0});
    settle();

    // short frames: two words, nine-bit data word, one position bit
    apply_setting(6'd2, 6'd9, 6'd1, 6'd31, 6'd0, 6'd0);
    queue_frame(24'h000000, 1'b0, 1'b0, 1'b1, 1'b1, 0, 1);
    queue_frame(24'h000000, 1'b0, 1'b0, 1'b0, 1'b1, 0, 1);
    queue_frame(24'h000001, 1'b1, 1'b0, 1'b1, 1'b1, 0, 1);
    queue_frame(24'h000001, 1'b0, 1'b1, 1'b1, 1'b1, 0, 1);
    repeat (16) all_ones.push_back(1'b1);
    pack_frame(all_ones, 2, 1'b1);
    // half a frame, then shrink the frame so the next word ends it
    rx_pending.push_back('{8'h00, 1'b1});
    settle();
    write_reg(CFG_FRAME_LEN, 6'd1);
    rx_pending.push_back('{8'h5A, 1'b0});
    settle();

    write_reg(CfgSpareLo, 6'h3F);
    write_reg(CfgSpareHi, 6'h2A);
    apply_setting(6'd8, 6'd32, 6'd24, 6'd24, 6'd0, 6'd0);
    run_setting(85);
    apply_setting(6'h26, 6'd32, 6'd16, 6'd12, 6'd1, 6'd0);
    run_setting(85);

    send_idle_pct = 57;
    recv_idle_pct = 12;
    apply_setting(6'd31, 6'd63, 6'd31, 6'd0, 6'd1, 6'd1);
    run_setting(85);
    apply_setting(6'd0, 6'd0, 6'd0, 6'd31, 6'd0, 6'd1);
    run_setting(85);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting(6'h2A, 6'd40, 6'd12, 6'd31, 6'd1, 6'd1);
    run_setting(85);
    apply_setting(6'd3, 6'd9, 6'd1, 6'd1, 6'd0, 6'd0);
    run_setting(85);

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
